>>> sv/mvg_pkg.sv
// Package: shared constants, types and state codes for the mosaic grid layout block.
`timescale 1ns / 1ps
`default_nettype none
package mvg_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int SIZE_BITS   = 13;
    localparam int IDX_W       = $clog2(MAX_SOURCES);
    localparam int CNT_W       = $clog2(MAX_SOURCES + 2);
    localparam int SUM_W       = SIZE_BITS + IDX_W + 1;
    localparam int RAM_W       = 2 * SIZE_BITS + IDX_W;

    // shared multiplier and divider widths
    localparam int MUL_A_W = 2 * SIZE_BITS;
    localparam int MUL_B_W = SUM_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 2 * SIZE_BITS + 4;
    localparam int DIV_D_W = SIZE_BITS + 1;
    localparam int DIV_C_W = $clog2(DIV_N_W);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_G_COLS,
        ST_G_COLS_W,
        ST_G_GW,
        ST_G_GW_W,
        ST_G_GH,
        ST_G_GH_W,
        ST_G_MA,
        ST_G_MC,
        ST_G_MAD,
        ST_G_MCB,
        ST_G_SEL,
        ST_G_CMP1,
        ST_G_CMP2,
        ST_G_DEC,
        ST_G_UPD,
        ST_P_RD,
        ST_P_LAT,
        ST_P_MU,
        ST_P_MV,
        ST_P_SEL,
        ST_P_DIM,
        ST_P_DIM_W,
        ST_P_NUM,
        ST_P_NUMS,
        ST_P_POS_W,
        ST_P_OUT
    } state_t;

endpackage
`default_nettype wire

>>> sv/mvg_if.sv
// Interfaces: source list input channel and placement output channel.
`timescale 1ns / 1ps
`default_nettype none
interface mvg_in_if;
    logic                          valid;
    logic                          ready;
    logic [mvg_pkg::SIZE_BITS-1:0] src_width;
    logic [mvg_pkg::SIZE_BITS-1:0] src_height;
    logic                          include_req;
    logic                          last_source;

    modport source (output valid, src_width, src_height, include_req, last_source,
                    input ready);
    modport sink (input valid, src_width, src_height, include_req, last_source,
                  output ready);
endinterface

interface mvg_out_if;
    logic                          valid;
    logic                          ready;
    logic [mvg_pkg::IDX_W-1:0]     source_index;
    logic [mvg_pkg::SIZE_BITS-1:0] xpos;
    logic [mvg_pkg::SIZE_BITS-1:0] ypos;
    logic [mvg_pkg::SIZE_BITS-1:0] out_width;
    logic [mvg_pkg::SIZE_BITS-1:0] out_height;
    logic                          last_placement;

    modport source (output valid, source_index, xpos, ypos, out_width, out_height,
                    last_placement, input ready);
    modport sink (input valid, source_index, xpos, ypos, out_width, out_height,
                  last_placement, output ready);
endinterface
`default_nettype wire

>>> sv/mvg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mvg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> sv/mvg_mul.sv
// Shared multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module mvg_mul (
    input  wire logic                        clk,
    input  wire logic [mvg_pkg::MUL_A_W-1:0] a,
    input  wire logic [mvg_pkg::MUL_B_W-1:0] b,
    output logic      [mvg_pkg::MUL_P_W-1:0] prod
);

    logic [mvg_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mvg_pkg::MUL_P_W'(a) * mvg_pkg::MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> sv/mvg_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mvg_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mvg_pkg::div_req_t           req,
    output logic                             busy,
    output logic      [mvg_pkg::DIV_N_W-1:0] quot
);

    logic                        busy_reg;
    logic [mvg_pkg::DIV_C_W-1:0] cnt_reg;
    logic [mvg_pkg::DIV_D_W-1:0] rem_reg;
    logic [mvg_pkg::DIV_D_W-1:0] dvs_reg;
    logic [mvg_pkg::DIV_N_W-1:0] quot_reg;
    logic [mvg_pkg::DIV_D_W:0]   shifted;
    logic                        fits;

    // trial subtract of the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, quot_reg[mvg_pkg::DIV_N_W-1]};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= mvg_pkg::DIV_C_W'(mvg_pkg::DIV_N_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? mvg_pkg::DIV_D_W'(shifted - {1'b0, dvs_reg})
                             : shifted[mvg_pkg::DIV_D_W-1:0];
            quot_reg <= {quot_reg[mvg_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule
`default_nettype wire

>>> sv/video_mosaic_grid_layout.sv
// Top level: source list loading, grid search and placement sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Sources are loaded one item per cycle while the block is idle; up to 16 are kept
// per list and entries with a zero size are skipped. The item carrying last_source
// starts the layout if at least one source was kept and both frame sizes are nonzero;
// during the layout in_ch.ready stays low. The layout sums the stored sizes, then tries
// row counts from 1 up to n+1, stopping at the first that does not improve the fit,
// each trial costing three passes through the shared restoring divider plus
// multiply/compare steps, then places each source with two more divider passes and
// multiply steps, plus any wait on out_ch.ready. Frame size is written through the
// APB port: frame_width at 0x0, frame_height at 0x4.
module video_mosaic_grid_layout (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mvg_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mvg_pkg::PDATA_W-1:0] pwdata,
    output logic      [mvg_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    mvg_in_if.sink                           in_ch,
    mvg_out_if.source                        out_ch
);

    localparam int SB = mvg_pkg::SIZE_BITS;
    localparam int CW = mvg_pkg::CNT_W;
    localparam int IW = mvg_pkg::IDX_W;

    mvg_pkg::state_t state_reg, state_next;

    logic [SB-1:0] fw_reg, fh_reg;
    logic [CW-1:0] inc_cnt_reg, load_cnt_reg, n_reg, k_reg, rows_reg;
    logic [IW-1:0] r_reg, c_reg;
    logic [mvg_pkg::SUM_W-1:0] sw_sum_reg, sh_sum_reg, a_reg, c_val_reg;
    logic [mvg_pkg::SUM_W-1:0] pn_reg, pd_reg, bn_reg, bd_reg;
    logic [mvg_pkg::MUL_P_W-1:0] t1_reg;
    logic [SB-1:0] cgw_reg, cgh_reg, bgw_reg, bgh_reg;
    logic [CW-1:0] ccols_reg, bcols_reg;
    logic [SB-1:0] sw1_reg, sh1_reg;
    logic [IW-1:0] idx1_reg;
    logic [mvg_pkg::MUL_A_W-1:0] pp_reg, tt_reg;
    logic wb_reg;
    logic [SB-1:0] ox_reg, oy_reg, ow_reg, oh_reg;
    logic olast_reg;

    // load side
    logic accept, store_ok, cfg_wr, go;
    logic [CW-1:0] inc_cnt_next;
    logic [IW-1:0] raddr;
    logic [mvg_pkg::RAM_W-1:0] rdata;

    // shared units
    logic [mvg_pkg::MUL_A_W-1:0] mul_a;
    logic [mvg_pkg::MUL_B_W-1:0] mul_b;
    logic [mvg_pkg::MUL_P_W-1:0] prod;
    mvg_pkg::div_req_t div_req;
    logic div_busy;
    logic [mvg_pkg::DIV_N_W-1:0] quot;
    logic [mvg_pkg::DIV_N_W-1:0] pos_num;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == mvg_pkg::REG_FRAME_HEIGHT)
                  ? mvg_pkg::PDATA_W'(fh_reg) : mvg_pkg::PDATA_W'(fw_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= '0;
            fh_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == mvg_pkg::REG_FRAME_HEIGHT)
            begin
                fh_reg <= pwdata[SB-1:0];
            end
            else
            begin
                fw_reg <= pwdata[SB-1:0];
            end
        end
    end

    // item acceptance and store write
    assign in_ch.ready = (state_reg == mvg_pkg::ST_IDLE);
    assign accept      = in_ch.valid & in_ch.ready;
    assign store_ok    = accept && (load_cnt_reg < CW'(mvg_pkg::MAX_SOURCES))
                         && in_ch.include_req && (in_ch.src_width != '0)
                         && (in_ch.src_height != '0)
                         && (inc_cnt_reg < CW'(mvg_pkg::MAX_SOURCES));
    assign inc_cnt_next = store_ok ? inc_cnt_reg + 1'b1 : inc_cnt_reg;
    assign go = (inc_cnt_next != '0) && (fw_reg != '0) && (fh_reg != '0);

    mvg_ram #(
        .WIDTH (mvg_pkg::RAM_W),
        .DEPTH (mvg_pkg::MAX_SOURCES)
    ) u_store (
        .clk   (clk),
        .we    (store_ok),
        .waddr (inc_cnt_reg[IW-1:0]),
        .wdata ({load_cnt_reg[IW-1:0], in_ch.src_width, in_ch.src_height}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign raddr = k_reg[IW-1:0];

    mvg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mvg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (quot)
    );

    assign pos_num = prod[mvg_pkg::DIV_N_W-1:0]
                   - mvg_pkg::DIV_N_W'(wb_reg ? pp_reg : tt_reg);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, multiplier operands and divider requests
    always_comb
    begin
        state_next       = state_reg;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            mvg_pkg::ST_IDLE:
            begin
                if (accept && in_ch.last_source && go)
                begin
                    state_next = mvg_pkg::ST_SUM_RD;
                end
            end
            mvg_pkg::ST_SUM_RD:   state_next = mvg_pkg::ST_SUM_ACC;
            mvg_pkg::ST_SUM_ACC:
            begin
                state_next = (k_reg + 1'b1 == n_reg) ? mvg_pkg::ST_G_COLS
                                                     : mvg_pkg::ST_SUM_RD;
            end
            mvg_pkg::ST_G_COLS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mvg_pkg::DIV_N_W'({1'b0, n_reg} + {1'b0, rows_reg} - 1'b1);
                div_req.divisor  = mvg_pkg::DIV_D_W'(rows_reg);
                state_next       = mvg_pkg::ST_G_COLS_W;
            end
            mvg_pkg::ST_G_COLS_W: if (!div_busy) state_next = mvg_pkg::ST_G_GW;
            mvg_pkg::ST_G_GW:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mvg_pkg::DIV_N_W'(fw_reg);
                div_req.divisor  = mvg_pkg::DIV_D_W'(ccols_reg);
                state_next       = mvg_pkg::ST_G_GW_W;
            end
            mvg_pkg::ST_G_GW_W:   if (!div_busy) state_next = mvg_pkg::ST_G_GH;
            mvg_pkg::ST_G_GH:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mvg_pkg::DIV_N_W'(fh_reg);
                div_req.divisor  = mvg_pkg::DIV_D_W'(rows_reg);
                state_next       = mvg_pkg::ST_G_GH_W;
            end
            mvg_pkg::ST_G_GH_W:   if (!div_busy) state_next = mvg_pkg::ST_G_MA;
            mvg_pkg::ST_G_MA:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(cgw_reg);
                mul_b      = mvg_pkg::MUL_B_W'(n_reg);
                state_next = mvg_pkg::ST_G_MC;
            end
            mvg_pkg::ST_G_MC:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(cgh_reg);
                mul_b      = mvg_pkg::MUL_B_W'(n_reg);
                state_next = mvg_pkg::ST_G_MAD;
            end
            mvg_pkg::ST_G_MAD:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(a_reg);
                mul_b      = mvg_pkg::MUL_B_W'(sh_sum_reg);
                state_next = mvg_pkg::ST_G_MCB;
            end
            mvg_pkg::ST_G_MCB:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(c_val_reg);
                mul_b      = mvg_pkg::MUL_B_W'(sw_sum_reg);
                state_next = mvg_pkg::ST_G_SEL;
            end
            mvg_pkg::ST_G_SEL:
            begin
                state_next = (rows_reg == CW'(1)) ? mvg_pkg::ST_G_UPD : mvg_pkg::ST_G_CMP1;
            end
            mvg_pkg::ST_G_CMP1:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(pn_reg);
                mul_b      = mvg_pkg::MUL_B_W'(bd_reg);
                state_next = mvg_pkg::ST_G_CMP2;
            end
            mvg_pkg::ST_G_CMP2:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(bn_reg);
                mul_b      = mvg_pkg::MUL_B_W'(pd_reg);
                state_next = mvg_pkg::ST_G_DEC;
            end
            mvg_pkg::ST_G_DEC:
            begin
                state_next = (t1_reg <= prod) ? mvg_pkg::ST_P_RD : mvg_pkg::ST_G_UPD;
            end
            mvg_pkg::ST_G_UPD:
            begin
                state_next = (rows_reg == n_reg + 1'b1) ? mvg_pkg::ST_P_RD
                                                        : mvg_pkg::ST_G_COLS;
            end
            mvg_pkg::ST_P_RD:     state_next = mvg_pkg::ST_P_LAT;
            mvg_pkg::ST_P_LAT:    state_next = mvg_pkg::ST_P_MU;
            mvg_pkg::ST_P_MU:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(bgw_reg);
                mul_b      = mvg_pkg::MUL_B_W'(sh1_reg);
                state_next = mvg_pkg::ST_P_MV;
            end
            mvg_pkg::ST_P_MV:
            begin
                mul_a      = mvg_pkg::MUL_A_W'(bgh_reg);
                mul_b      = mvg_pkg::MUL_B_W'(sw1_reg);
                state_next = mvg_pkg::ST_P_SEL;
            end
            mvg_pkg::ST_P_SEL:
            begin
                // width bound places by column, height bound by row
                if (mvg_pkg::MUL_P_W'(pp_reg) <= prod)
                begin
                    mul_a = mvg_pkg::MUL_A_W'(bgw_reg);
                    mul_b = mvg_pkg::MUL_B_W'(c_reg);
                end
                else
                begin
                    mul_a = mvg_pkg::MUL_A_W'(bgh_reg);
                    mul_b = mvg_pkg::MUL_B_W'(r_reg);
                end
                state_next = mvg_pkg::ST_P_DIM;
            end
            mvg_pkg::ST_P_DIM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mvg_pkg::DIV_N_W'(wb_reg ? pp_reg : tt_reg);
                div_req.divisor  = mvg_pkg::DIV_D_W'(wb_reg ? sw1_reg : sh1_reg);
                state_next       = mvg_pkg::ST_P_DIM_W;
            end
            mvg_pkg::ST_P_DIM_W:  if (!div_busy) state_next = mvg_pkg::ST_P_NUM;
            mvg_pkg::ST_P_NUM:
            begin
                mul_a      = wb_reg ? tt_reg : pp_reg;
                mul_b      = mvg_pkg::MUL_B_W'(wb_reg ? {r_reg, 1'b1} : {c_reg, 1'b1});
                state_next = mvg_pkg::ST_P_NUMS;
            end
            mvg_pkg::ST_P_NUMS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = pos_num;
                div_req.divisor  = wb_reg ? {sw1_reg, 1'b0} : {sh1_reg, 1'b0};
                state_next       = mvg_pkg::ST_P_POS_W;
            end
            mvg_pkg::ST_P_POS_W:  if (!div_busy) state_next = mvg_pkg::ST_P_OUT;
            mvg_pkg::ST_P_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = olast_reg ? mvg_pkg::ST_IDLE : mvg_pkg::ST_P_RD;
                end
            end
            default:              state_next = mvg_pkg::ST_IDLE;
        endcase
    end

    // list counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_cnt_reg  <= '0;
            load_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (in_ch.last_source)
            begin
                inc_cnt_reg  <= '0;
                load_cnt_reg <= '0;
            end
            else
            begin
                inc_cnt_reg <= inc_cnt_next;
                if (load_cnt_reg < CW'(mvg_pkg::MAX_SOURCES))
                begin
                    load_cnt_reg <= load_cnt_reg + 1'b1;
                end
            end
        end
    end

    // layout datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mvg_pkg::ST_IDLE:
            begin
                n_reg      <= inc_cnt_next;
                k_reg      <= '0;
                sw_sum_reg <= '0;
                sh_sum_reg <= '0;
                rows_reg   <= CW'(1);
            end
            mvg_pkg::ST_SUM_ACC:
            begin
                sw_sum_reg <= sw_sum_reg + mvg_pkg::SUM_W'(rdata[2*SB-1:SB]);
                sh_sum_reg <= sh_sum_reg + mvg_pkg::SUM_W'(rdata[SB-1:0]);
                k_reg      <= k_reg + 1'b1;
            end
            mvg_pkg::ST_G_COLS_W: ccols_reg <= quot[CW-1:0];
            mvg_pkg::ST_G_GW_W:   cgw_reg   <= quot[SB-1:0];
            mvg_pkg::ST_G_GH_W:   cgh_reg   <= quot[SB-1:0];
            mvg_pkg::ST_G_MC:     a_reg     <= prod[mvg_pkg::SUM_W-1:0];
            mvg_pkg::ST_G_MAD:    c_val_reg <= prod[mvg_pkg::SUM_W-1:0];
            mvg_pkg::ST_G_MCB:    t1_reg    <= prod;
            mvg_pkg::ST_G_SEL:
            begin
                // fit scale is the smaller of the two fractions
                if (t1_reg <= prod)
                begin
                    pn_reg <= a_reg;
                    pd_reg <= sw_sum_reg;
                end
                else
                begin
                    pn_reg <= c_val_reg;
                    pd_reg <= sh_sum_reg;
                end
            end
            mvg_pkg::ST_G_CMP2:   t1_reg <= prod;
            mvg_pkg::ST_G_DEC:
            begin
                k_reg <= '0;
                r_reg <= '0;
                c_reg <= '0;
            end
            mvg_pkg::ST_G_UPD:
            begin
                bn_reg    <= pn_reg;
                bd_reg    <= pd_reg;
                bgw_reg   <= cgw_reg;
                bgh_reg   <= cgh_reg;
                bcols_reg <= ccols_reg;
                rows_reg  <= rows_reg + 1'b1;
                k_reg     <= '0;
                r_reg     <= '0;
                c_reg     <= '0;
            end
            mvg_pkg::ST_P_LAT:
            begin
                idx1_reg <= rdata[mvg_pkg::RAM_W-1:2*SB];
                sw1_reg  <= rdata[2*SB-1:SB];
                sh1_reg  <= rdata[SB-1:0];
            end
            mvg_pkg::ST_P_MV:     pp_reg <= prod[mvg_pkg::MUL_A_W-1:0];
            mvg_pkg::ST_P_SEL:
            begin
                tt_reg <= prod[mvg_pkg::MUL_A_W-1:0];
                wb_reg <= mvg_pkg::MUL_P_W'(pp_reg) <= prod;
            end
            mvg_pkg::ST_P_DIM:
            begin
                if (wb_reg)
                begin
                    ox_reg <= prod[SB-1:0];
                    ow_reg <= bgw_reg;
                end
                else
                begin
                    oy_reg <= prod[SB-1:0];
                    oh_reg <= bgh_reg;
                end
                olast_reg <= (k_reg + 1'b1 == n_reg);
            end
            mvg_pkg::ST_P_DIM_W:
            begin
                if (wb_reg)
                begin
                    oh_reg <= quot[SB-1:0];
                end
                else
                begin
                    ow_reg <= quot[SB-1:0];
                end
            end
            mvg_pkg::ST_P_POS_W:
            begin
                if (wb_reg)
                begin
                    oy_reg <= quot[SB-1:0];
                end
                else
                begin
                    ox_reg <= quot[SB-1:0];
                end
            end
            mvg_pkg::ST_P_OUT:
            begin
                if (out_ch.ready)
                begin
                    k_reg <= k_reg + 1'b1;
                    if (CW'(c_reg) + 1'b1 == bcols_reg)
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + 1'b1;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // result channel
    assign out_ch.valid          = (state_reg == mvg_pkg::ST_P_OUT);
    assign out_ch.source_index   = idx1_reg;
    assign out_ch.xpos           = ox_reg;
    assign out_ch.ypos           = oy_reg;
    assign out_ch.out_width      = ow_reg;
    assign out_ch.out_height     = oh_reg;
    assign out_ch.last_placement = olast_reg;

    assert property (@(posedge clk) disable iff (!rst_n) out_ch.valid |-> !in_ch.ready)
        else $error("input taken while a placement is pending");
    assert property (@(posedge clk) disable iff (!rst_n) inc_cnt_reg <= load_cnt_reg)
        else $error("included count exceeds loaded count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mvg_pkg::ST_P_OUT) |-> (k_reg < n_reg))
        else $error("placement index beyond source count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_placement) |=> in_ch.ready)
        else $error("block not idle after final placement");

endmodule
`default_nettype wire

>>> bench/mvg_layout_checker.sv
// Checker: watches the channels and APB writes, predicts placements and compares them.
`timescale 1ns / 1ps
`default_nettype none
module mvg_layout_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic                        pready,
    input  wire logic [mvg_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mvg_pkg::PDATA_W-1:0] pwdata,
    mvg_in_if                                in_ch,
    mvg_out_if                               out_ch,
    output int                               fail_count,
    output int                               pending
);

    typedef struct {
        logic [mvg_pkg::IDX_W-1:0]     source_index;
        logic [mvg_pkg::SIZE_BITS-1:0] xpos;
        logic [mvg_pkg::SIZE_BITS-1:0] ypos;
        logic [mvg_pkg::SIZE_BITS-1:0] out_width;
        logic [mvg_pkg::SIZE_BITS-1:0] out_height;
        logic                          last_placement;
    } placement_t;

    placement_t placement_q[$];

    // predictor copy of registers and list state
    longint unsigned fw, fh;
    longint unsigned wid_mem[mvg_pkg::MAX_SOURCES];
    longint unsigned hgt_mem[mvg_pkg::MAX_SOURCES];
    longint unsigned idx_mem[mvg_pkg::MAX_SOURCES];
    int              n_incl, n_loaded;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // fit scale of one row count as a fraction num/den
    task automatic fit_scale(input longint unsigned rows, input longint unsigned n,
                             input longint unsigned sw, input longint unsigned sh,
                             output longint unsigned num, output longint unsigned den);
        longint unsigned cols, gw, gh;
        cols = (n + rows - 1) / rows;
        gw   = fw / cols;
        gh   = fh / rows;
        if (gw * n * sh <= gh * n * sw)
        begin
            num = gw * n;
            den = sw;
        end
        else
        begin
            num = gh * n;
            den = sh;
        end
    endtask

    // grid search and per-source placement for the list just closed
    task automatic place_sources(input int n);
        longint unsigned sw, sh, rows, cols, gw, gh, bn, bd, pn, pd;
        longint unsigned r, c, w1, h1, ow, oh, x, y;
        placement_t      p;
        sw = 0;
        sh = 0;
        for (int k = 0; k < n; k++)
        begin
            sw += wid_mem[k];
            sh += hgt_mem[k];
        end
        rows = 1;
        fit_scale(1, n, sw, sh, bn, bd);
        for (longint unsigned k = 2; k <= n + 1; k++)
        begin
            fit_scale(k, n, sw, sh, pn, pd);
            if (pn * bd <= bn * pd)
                break;
            rows = k;
            bn   = pn;
            bd   = pd;
        end
        cols = (n + rows - 1) / rows;
        gw   = fw / cols;
        gh   = fh / rows;
        for (int k = 0; k < n; k++)
        begin
            r  = k / cols;
            c  = k % cols;
            w1 = wid_mem[k];
            h1 = hgt_mem[k];
            if (gw * h1 <= gh * w1)
            begin
                ow = gw;
                oh = (h1 * gw) / w1;
                x  = c * gw;
                y  = (2 * r * gh * w1 + gh * w1 - h1 * gw) / (2 * w1);
            end
            else
            begin
                oh = gh;
                ow = (w1 * gh) / h1;
                y  = r * gh;
                x  = (2 * c * gw * h1 + gw * h1 - w1 * gh) / (2 * h1);
            end
            p.source_index   = idx_mem[k][mvg_pkg::IDX_W-1:0];
            p.xpos           = x[mvg_pkg::SIZE_BITS-1:0];
            p.ypos           = y[mvg_pkg::SIZE_BITS-1:0];
            p.out_width      = ow[mvg_pkg::SIZE_BITS-1:0];
            p.out_height     = oh[mvg_pkg::SIZE_BITS-1:0];
            p.last_placement = (k + 1 == n);
            placement_q = {placement_q, p};
        end
    endtask

    // one accepted source item
    task automatic load_source(input longint unsigned w, input longint unsigned h,
                               input logic inc, input logic last);
        int n;
        if (n_loaded < mvg_pkg::MAX_SOURCES)
        begin
            if (inc && w != 0 && h != 0 && n_incl < mvg_pkg::MAX_SOURCES)
            begin
                wid_mem[n_incl] = w;
                hgt_mem[n_incl] = h;
                idx_mem[n_incl] = n_loaded;
                n_incl++;
            end
            n_loaded++;
        end
        if (last)
        begin
            n        = n_incl;
            n_incl   = 0;
            n_loaded = 0;
            if (n != 0 && fw != 0 && fh != 0)
                place_sources(n);
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        fw         = 0;
        fh         = 0;
        n_incl     = 0;
        n_loaded   = 0;
    end

    always @(posedge clk)
    begin
        placement_t e;
        if (rst_n)
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == mvg_pkg::REG_FRAME_HEIGHT)
                    fh = pwdata[mvg_pkg::SIZE_BITS-1:0];
                else
                    fw = pwdata[mvg_pkg::SIZE_BITS-1:0];
            end
            // compare placements
            if (out_ch.valid && out_ch.ready)
            begin
                if (placement_q.size() == 0)
                    report("placement with none expected");
                else
                begin
                    e = placement_q.pop_front();
                    if (out_ch.source_index !== e.source_index)
                        report($sformatf("source_index %0d exp %0d",
                                         out_ch.source_index, e.source_index));
                    if (out_ch.xpos !== e.xpos)
                        report($sformatf("xpos %0d exp %0d", out_ch.xpos, e.xpos));
                    if (out_ch.ypos !== e.ypos)
                        report($sformatf("ypos %0d exp %0d", out_ch.ypos, e.ypos));
                    if (out_ch.out_width !== e.out_width)
                        report($sformatf("out_width %0d exp %0d",
                                         out_ch.out_width, e.out_width));
                    if (out_ch.out_height !== e.out_height)
                        report($sformatf("out_height %0d exp %0d",
                                         out_ch.out_height, e.out_height));
                    if (out_ch.last_placement !== e.last_placement)
                        report($sformatf("last_placement %0b exp %0b",
                                         out_ch.last_placement, e.last_placement));
                end
            end
            // accepted sources
            if (in_ch.valid && in_ch.ready)
                load_source(in_ch.src_width, in_ch.src_height,
                            in_ch.include_req, in_ch.last_source);
            pending = placement_q.size();
        end
    end
endmodule
`default_nettype wire

>>> bench/tb_video_mosaic_grid_layout.sv
// Testbench top: clock, reset, source list stimulus, frame size writes and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_video_mosaic_grid_layout;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 4000;
    localparam int RANDOM_ITEMS   = 293;
    localparam logic [mvg_pkg::PADDR_W-1:0] ADDR_FW =
        mvg_pkg::PADDR_W'(4 * mvg_pkg::REG_FRAME_WIDTH);
    localparam logic [mvg_pkg::PADDR_W-1:0] ADDR_FH =
        mvg_pkg::PADDR_W'(4 * mvg_pkg::REG_FRAME_HEIGHT);

    logic                        clk;
    logic                        rst_n;
    logic                        psel, penable, pwrite;
    logic [mvg_pkg::PADDR_W-1:0] paddr;
    logic [mvg_pkg::PDATA_W-1:0] pwdata;
    logic [mvg_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    int                          fail_count, pending;
    int                          tx_idle, rx_idle;
    int                          stall_cnt;
    int                          sent;

    mvg_in_if  in_ch ();
    mvg_out_if out_ch ();

    video_mosaic_grid_layout u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    mvg_layout_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= rx_idle);

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [mvg_pkg::PADDR_W-1:0] addr, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= mvg_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending, wait for all placements, then write the frame size
    task automatic set_frame(input int w, input int h);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        reg_write(ADDR_FW, w);
        reg_write(ADDR_FH, h);
    endtask

    // one source item; valid stays high across back-to-back items
    task automatic send_source(input int w, input int h, input logic inc, input logic last);
        in_ch.valid       <= 1'b1;
        in_ch.src_width   <= mvg_pkg::SIZE_BITS'(w);
        in_ch.src_height  <= mvg_pkg::SIZE_BITS'(h);
        in_ch.include_req <= inc;
        in_ch.last_source <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
        if ($urandom_range(99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic int pick_size();
        case ($urandom_range(9))
            0:       return ($urandom_range(19) == 0) ? 0 : 8191;
            1:       return $urandom_range(1, 16);
            default: return $urandom_range(1, 8191);
        endcase
    endfunction

    // a random source list; mostly short, sometimes past the store depth
    task automatic send_list(input int len);
        for (int i = 0; i < len; i++)
            send_source(pick_size(), pick_size(), $urandom_range(99) < 85, i == len - 1);
    endtask

    initial
    begin
        int fw_set[6] = '{1920, 8191, 1, 0, 8191, 3};
        int fh_set[6] = '{1080, 8191, 1, 500, 1, 7};
        int len;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.src_width   = '0;
        in_ch.src_height  = '0;
        in_ch.include_req = 1'b0;
        in_ch.last_source = 1'b0;
        out_ch.ready      = 1'b0;
        stall_cnt         = 0;
        sent              = 0;
        tx_idle           = 20;
        rx_idle           = 81;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: list with frame size still unknown, then extremes
        send_source(640, 480, 1'b1, 1'b1);
        set_frame(1920, 1080);
        send_source(8191, 1, 1'b1, 1'b1);
        send_source(1, 8191, 1'b1, 1'b0);
        send_source(0, 100, 1'b1, 1'b0);
        send_source(100, 0, 1'b1, 1'b0);
        send_source(300, 200, 1'b0, 1'b0);
        send_source(8191, 8191, 1'b1, 1'b1);
        send_source(500, 500, 1'b0, 1'b1);
        send_source(0, 0, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++)
            send_source(320, 240, 1'b1, i == 3);
        set_frame(1, 1);
        send_source(8191, 8191, 1'b1, 1'b0);
        send_source(16, 9, 1'b1, 1'b0);
        send_source(1, 1, 1'b1, 1'b1);
        set_frame(0, 8191);
        send_source(100, 100, 1'b1, 1'b1);

        // random phases over several frame sizes
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                set_frame($urandom_range(1, 8191), $urandom_range(1, 8191));
            else
                set_frame(fw_set[ph], fh_set[ph]);
            while (sent < 17 + (ph + 1) * RANDOM_ITEMS / 6)
            begin
                if (sent > 17 + 2 * RANDOM_ITEMS / 3)
                begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
                else if (sent > 17 + RANDOM_ITEMS / 3)
                begin
                    tx_idle = 81;
                    rx_idle = 20;
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 8);
                send_list(len);
            end
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
